### rtl/bfha_pkg.sv
// Shared types, constants and helpers for the best-fit heap allocator.
// Used by bfha_ram, bfha_ctrl and best_fit_heap_allocator.
`timescale 1ns / 1ps
`default_nettype none

package bfha_pkg;

  localparam int HEAP_BYTES  = 4096;
  localparam int ALIGN_BYTES = 16;
  localparam int MIN_SPLIT   = 16;
  localparam int HDR_BYTES   = 8;
  localparam int HEAP_WORDS  = HEAP_BYTES / 8;

  // word index, stored word (a byte count below HEAP_BYTES plus tag bits),
  // byte offset with room for one heap length of overrun
  localparam int ADDR_W = $clog2(HEAP_WORDS);
  localparam int WORD_W = ADDR_W + 3;
  localparam int OFS_W  = ADDR_W + 4;

  localparam int REQ_W = 12;
  localparam int PAY_W = 12;

  localparam logic [WORD_W-1:0] BIT_BUSY = WORD_W'(1);
  localparam logic [WORD_W-1:0] BIT_PREV = WORD_W'(2);
  localparam logic [WORD_W-1:0] END_MARK = WORD_W'(1);

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic             granted;
    logic [PAY_W-1:0] offset;
  } res_t;

  // block size held in a header or footer word
  function automatic logic [OFS_W-1:0] size_of(input logic [WORD_W-1:0] w);
    logic [OFS_W-1:0] s;
    s = {1'b0, w};
    s[3:0] = 4'b0000;
    return s;
  endfunction

  // heap contents after reset: pad, one free block, its footer, end mark
  function automatic logic [WORD_W-1:0] init_word(input logic [ADDR_W-1:0] idx);
    logic [WORD_W-1:0] v;
    v = '0;
    if (idx == ADDR_W'(1)) begin
      v = WORD_W'(HEAP_BYTES - ALIGN_BYTES) | BIT_PREV;
    end else if (idx == ADDR_W'(HEAP_WORDS - 2)) begin
      v = WORD_W'(HEAP_BYTES - ALIGN_BYTES);
    end else if (idx == ADDR_W'(HEAP_WORDS - 1)) begin
      v = END_MARK;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/bfha_ram.sv
// Single-port heap RAM with registered read data.
// Depends on bfha_pkg for widths and the request struct.
`timescale 1ns / 1ps
`default_nettype none

module bfha_ram (
  input  logic                      clk_i,
  input  bfha_pkg::mem_req_t        req_i,
  output logic [bfha_pkg::WORD_W-1:0] rdata_o
);
  import bfha_pkg::*;

  logic [WORD_W-1:0] mem [HEAP_WORDS];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem[req_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/bfha_ctrl.sv
// Sequencer of the allocator: heap init sweep, best-fit walk, split and tag
// updates, all through one shared adder. Depends on bfha_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfha_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  logic [bfha_pkg::REQ_W-1:0]  req_size_i,
  input  logic                        out_free_i,
  output logic                        res_valid_o,
  output bfha_pkg::res_t              res_o,
  output bfha_pkg::mem_req_t          mem_req_o,
  input  logic [bfha_pkg::WORD_W-1:0] mem_rdata_i
);
  import bfha_pkg::*;

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_EVAL = 4'd3;
  localparam logic [3:0] S_FIN  = 4'd4;
  localparam logic [3:0] S_SPL  = 4'd5;
  localparam logic [3:0] S_FTR  = 4'd6;
  localparam logic [3:0] S_HDR  = 4'd7;
  localparam logic [3:0] S_NRD  = 4'd8;
  localparam logic [3:0] S_NWR  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]        state_q, state_d;
  logic [OFS_W-1:0]  cur_q, cur_d;
  logic [OFS_W-1:0]  need_q, need_d;
  logic [OFS_W-1:0]  best_q, best_d;
  logic [OFS_W-1:0]  best_sz_q, best_sz_d;
  logic [WORD_W-1:0] best_w_q, best_w_d;
  logic [OFS_W-1:0]  rem_q, rem_d;
  logic [OFS_W-1:0]  split_q, split_d;
  logic [OFS_W-1:0]  nxt_q, nxt_d;
  logic              found_q, found_d;
  logic              granted_q, granted_d;

  // shared adder
  logic [OFS_W-1:0] alu_a, alu_b, alu_sum;
  logic             alu_cin;
  assign alu_sum = alu_a + alu_b + OFS_W'(alu_cin);

  logic [OFS_W-1:0]  sz;
  logic              do_split;
  logic [OFS_W-1:0]  need_calc;
  logic [WORD_W-1:0] hdr;

  assign sz       = size_of(mem_rdata_i);
  assign do_split = (rem_q >= OFS_W'(MIN_SPLIT));

  always_comb begin
    need_calc = {1'b0, req_size_i} + OFS_W'(HDR_BYTES + ALIGN_BYTES - 1);
    need_calc[3:0] = 4'b0000;
  end

  always_comb begin
    if (do_split) begin
      hdr = need_q[WORD_W-1:0] | (best_w_q & BIT_PREV) | BIT_BUSY;
    end else begin
      hdr = best_w_q | BIT_BUSY;
    end
  end

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    need_d    = need_q;
    best_d    = best_q;
    best_sz_d = best_sz_q;
    best_w_d  = best_w_q;
    rem_d     = rem_q;
    split_d   = split_q;
    nxt_d     = nxt_q;
    found_d   = found_q;
    granted_d = granted_q;
    alu_a     = cur_q;
    alu_b     = sz;
    alu_cin   = 1'b0;
    mem_req_o = '0;

    case (state_q)
      S_INIT: begin
        mem_req_o.en    = 1'b1;
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = cur_q[ADDR_W-1:0];
        mem_req_o.wdata = init_word(cur_q[ADDR_W-1:0]);
        alu_b           = OFS_W'(1);
        cur_d           = alu_sum;
        if (cur_q[ADDR_W-1:0] == ADDR_W'(HEAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          need_d  = need_calc;
          cur_d   = OFS_W'(HDR_BYTES);
          found_d = 1'b0;
          if (req_size_i == '0) begin
            granted_d = 1'b0;
            state_d   = S_DONE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (cur_q[OFS_W-1]) begin
          state_d = S_FIN;
        end else begin
          mem_req_o.en   = 1'b1;
          mem_req_o.addr = cur_q[OFS_W-2:3];
          state_d        = S_EVAL;
        end
      end
      S_EVAL: begin
        if (mem_rdata_i == END_MARK || sz == '0) begin
          state_d = S_FIN;
        end else begin
          if ((mem_rdata_i & BIT_BUSY) == '0 && sz >= need_q &&
              (!found_q || sz < best_sz_q)) begin
            found_d   = 1'b1;
            best_d    = cur_q;
            best_sz_d = sz;
            best_w_d  = mem_rdata_i;
          end
          cur_d   = alu_sum;
          state_d = S_RD;
        end
      end
      S_FIN: begin
        if (!found_q) begin
          granted_d = 1'b0;
          state_d   = S_DONE;
        end else begin
          alu_a   = best_sz_q;
          alu_b   = ~need_q;
          alu_cin = 1'b1;
          rem_d   = alu_sum;
          state_d = S_SPL;
        end
      end
      S_SPL: begin
        if (do_split) begin
          alu_a           = best_q;
          alu_b           = need_q;
          split_d         = alu_sum;
          mem_req_o.en    = !alu_sum[OFS_W-1];
          mem_req_o.we    = 1'b1;
          mem_req_o.addr  = alu_sum[OFS_W-2:3];
          mem_req_o.wdata = rem_q[WORD_W-1:0] | BIT_PREV;
          state_d         = S_FTR;
        end else begin
          state_d = S_HDR;
        end
      end
      S_FTR: begin
        // split point sits 8 past a 16-byte boundary, so dropping bit 3 is the -8
        alu_a           = {split_q[OFS_W-1:4], 4'b0000};
        alu_b           = rem_q;
        mem_req_o.en    = !alu_sum[OFS_W-1];
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = alu_sum[OFS_W-2:3];
        mem_req_o.wdata = rem_q[WORD_W-1:0];
        state_d         = S_HDR;
      end
      S_HDR: begin
        mem_req_o.en    = !best_q[OFS_W-1];
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = best_q[OFS_W-2:3];
        mem_req_o.wdata = hdr;
        alu_a           = best_q;
        alu_b           = size_of(hdr);
        nxt_d           = alu_sum;
        state_d         = S_NRD;
      end
      S_NRD: begin
        granted_d = 1'b1;
        if (nxt_q[OFS_W-1]) begin
          state_d = S_DONE;
        end else begin
          mem_req_o.en   = 1'b1;
          mem_req_o.addr = nxt_q[OFS_W-2:3];
          state_d        = S_NWR;
        end
      end
      S_NWR: begin
        if (mem_rdata_i != END_MARK) begin
          mem_req_o.en    = 1'b1;
          mem_req_o.we    = 1'b1;
          mem_req_o.addr  = nxt_q[OFS_W-2:3];
          mem_req_o.wdata = mem_rdata_i | BIT_PREV;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      cur_q     <= '0;
      found_q   <= 1'b0;
      granted_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      found_q   <= found_d;
      granted_q <= granted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q    <= need_d;
    best_q    <= best_d;
    best_sz_q <= best_sz_d;
    best_w_q  <= best_w_d;
    rem_q     <= rem_d;
    split_q   <= split_d;
    nxt_q     <= nxt_d;
  end

  assign req_ready_o    = (state_q == S_IDLE);
  assign res_valid_o    = (state_q == S_DONE) && out_free_i;
  assign res_o.granted  = granted_q;
  assign res_o.offset   = granted_q ? (best_q[PAY_W-1:0] + PAY_W'(HDR_BYTES)) : '0;

endmodule

`default_nettype wire

### rtl/best_fit_heap_allocator.sv
// Best-fit allocator over an implicit block list with boundary tags.
// Each request reads every block header, end mark included, then does the split,
// tag updates and result. One request at a time: tready stays low until the
// result is in the output register. A size of zero answers without a heap walk.
// After reset the heap RAM is initialized by a sweep, one word a cycle, with
// tready low.
`timescale 1ns / 1ps
`default_nettype none

module best_fit_heap_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] request_size, [15:12] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] granted, [12:1] payload_offset, [15:13] zero
);
  import bfha_pkg::*;

  mem_req_t          mem_req;
  logic [WORD_W-1:0] mem_rdata;
  res_t              res;
  logic              res_valid;
  logic              out_free;
  logic              out_valid_q;
  res_t              out_q;

  assign out_free = !out_valid_q || m_axis_tready;

  bfha_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  bfha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_size_i  (s_axis_tdata[REQ_W-1:0]),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.offset, out_q.granted};

  // a failed request carries a zero offset
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[12:1] == '0)
    else $error("failed allocation with nonzero offset");

  // granted payloads are 16-byte aligned
  a_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[4:1] == 4'b0000)
    else $error("granted payload offset not aligned");

  // every request keeps the sequencer busy past the accept cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready asserted right after accepting a request");

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking bench for best_fit_heap_allocator: directed and random allocation
// requests, checked against a best-fit model of the heap. Depends on rtl/bfha_pkg.sv.
`timescale 1ns / 1ps

module testbench;
  import bfha_pkg::*;

  localparam int IDLE_PCT     = 29;
  localparam int RANDOM_ITEMS = 985;
  localparam int HOLD_AT      = 150;   // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 600;   // one full heap walk and then some

  typedef struct {
    logic [REQ_W-1:0] size;
    bit               typed;
    res_t             grant;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [15:0] s_data  = '0;
  logic        m_ready = 1'b0;
  wire         s_ready;
  wire         m_valid;
  wire  [15:0] m_data;

  bit   [63:0] heap_img [HEAP_WORDS];
  res_t        pending_grants [$];
  int          mismatches   = 0;
  int          results_seen = 0;
  int          hold_left    = 0;
  bit          hold_started = 1'b0;
  bit          gaps_on      = 1'b1;

  // size, typed, expected grant (only read when typed)
  stim_row_t directed_rows [15] = '{
    '{12'd0,    1'b1, '{1'b0, 12'd0}},
    '{12'd4095, 1'b1, '{1'b0, 12'd0}},
    '{12'd4073, 1'b1, '{1'b0, 12'd0}},
    '{12'd1,    1'b1, '{1'b1, 12'd16}},
    '{12'd8,    1'b1, '{1'b1, 12'd32}},
    '{12'd9,    1'b1, '{1'b1, 12'd48}},
    '{12'd16,   1'b0, '{1'b0, 12'd0}},
    '{12'd24,   1'b0, '{1'b0, 12'd0}},
    '{12'd25,   1'b0, '{1'b0, 12'd0}},
    '{12'd0,    1'b1, '{1'b0, 12'd0}},
    '{12'd100,  1'b0, '{1'b0, 12'd0}},
    '{12'd4094, 1'b1, '{1'b0, 12'd0}},
    '{12'd1000, 1'b0, '{1'b0, 12'd0}},
    '{12'd7,    1'b0, '{1'b0, 12'd0}},
    '{12'd3000, 1'b0, '{1'b0, 12'd0}}
  };

  best_fit_heap_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit [63:0] heap_rd(input bit [63:0] ofs);
    if (ofs / 8 < HEAP_WORDS) return heap_img[ofs / 8];
    return 64'(END_MARK);
  endfunction

  function automatic void heap_wr(input bit [63:0] ofs, input bit [63:0] v);
    if (ofs / 8 < HEAP_WORDS) heap_img[ofs / 8] = v;
  endfunction

  // Walk the block list; report the smallest free block that holds need bytes
  // (first one wins a tie) and the widest free block seen.
  function automatic bit scan_heap(input bit [63:0] need, output bit [63:0] at,
                                   output bit [63:0] sz, output bit [63:0] widest);
    bit [63:0] cur;
    bit [63:0] w;
    bit [63:0] bsz;
    bit        found;
    found  = 1'b0;
    at     = '0;
    sz     = '0;
    widest = '0;
    cur    = HDR_BYTES;
    for (int steps = 0; steps < HEAP_WORDS; steps++) begin
      if (cur / 8 >= HEAP_WORDS) break;
      w = heap_img[cur / 8];
      if (w == END_MARK) break;
      bsz = w & ~64'(ALIGN_BYTES - 1);
      if (bsz == 0) break;
      if (!w[0]) begin
        if (bsz > widest) widest = bsz;
        if (bsz >= need && (!found || bsz < sz)) begin
          found = 1'b1;
          at    = cur;
          sz    = bsz;
        end
      end
      cur += bsz;
    end
    return found;
  endfunction

  function automatic res_t best_fit_alloc(input logic [REQ_W-1:0] req);
    res_t      r;
    bit [63:0] need;
    bit [63:0] at;
    bit [63:0] sz;
    bit [63:0] widest;
    bit [63:0] rem;
    bit [63:0] hdr;
    bit [63:0] nxt;
    r = '0;
    if (req == '0) return r;
    need = (64'(req) + HDR_BYTES + ALIGN_BYTES - 1) & ~64'(ALIGN_BYTES - 1);
    if (!scan_heap(need, at, sz, widest)) return r;
    hdr = heap_rd(at);
    rem = sz - need;
    if (rem >= MIN_SPLIT) begin
      // split off the tail as a free block with header and footer
      heap_wr(at + need, rem | BIT_PREV);
      heap_wr(at + need + rem - HDR_BYTES, rem);
      hdr = need | (hdr & BIT_PREV) | BIT_BUSY;
    end else begin
      hdr = hdr | BIT_BUSY;
    end
    heap_wr(at, hdr);
    nxt = at + (hdr & ~64'(ALIGN_BYTES - 1));
    if (heap_rd(nxt) != END_MARK) heap_wr(nxt, heap_rd(nxt) | BIT_PREV);
    r.granted = 1'b1;
    r.offset  = PAY_W'(at + HDR_BYTES);
    return r;
  endfunction

  task automatic put_request(input logic [REQ_W-1:0] size, input bit typed, input res_t lit);
    res_t model;
    if (gaps_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        @(negedge clk_i);
        s_valid <= 1'b0;
      end
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_data  <= {4'b0000, size};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    model = best_fit_alloc(size);
    pending_grants.push_back(typed ? lit : model);
  endtask

  // receiver: random back-pressure plus one long hold-off
  always @(negedge clk_i) begin
    if (results_seen == HOLD_AT && !hold_started) begin
      hold_started = 1'b1;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin : check_beat
    res_t want;
    if (rst_ni && m_valid && m_ready) begin
      results_seen++;
      if (pending_grants.size() == 0) begin
        $error("result beat with no request outstanding: tdata=%h", m_data);
        mismatches++;
      end else begin
        want = pending_grants.pop_front();
        if (m_data[0] !== want.granted) begin
          $error("granted: expected %0d, actual %0d", want.granted, m_data[0]);
          mismatches++;
        end
        if (m_data[12:1] !== want.offset) begin
          $error("payload_offset: expected %0d, actual %0d", want.offset, m_data[12:1]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int          pick;
    bit   [63:0] at;
    bit   [63:0] sz;
    bit   [63:0] widest;
    bit   [63:0] lo;
    logic [11:0] size;

    foreach (heap_img[i]) heap_img[i] = '0;
    heap_img[1]              = 64'(HEAP_BYTES - ALIGN_BYTES) | BIT_PREV;
    heap_img[HEAP_WORDS - 2] = 64'(HEAP_BYTES - ALIGN_BYTES);
    heap_img[HEAP_WORDS - 1] = END_MARK;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      put_request(directed_rows[i].size, directed_rows[i].typed, directed_rows[i].grant);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gaps_on = !(i >= 300 && i < 450);
      if (i == 500) begin
        // drop valid and let the block drain completely
        @(negedge clk_i);
        s_valid <= 1'b0;
        wait (pending_grants.size() == 0);
      end
      void'(scan_heap(64'hFFFF_FFFF_FFFF_FFFF, at, sz, widest));
      pick = $urandom_range(99);
      if (pick < 10) begin
        size = '0;
      end else if (pick < 25) begin
        // too big for any free block
        lo   = (widest >= 8) ? widest - 7 : 64'd1;
        size = 12'($urandom_range(4095, int'(lo)));
      end else if (pick < 28) begin
        size = 12'($urandom_range(4095));
      end else if (pick < 40 && widest >= 48 && widest <= 512) begin
        // hand out the whole block, or leave the smallest splittable tail
        if ($urandom_range(1))
          size = 12'(widest - 8 - $urandom_range(7));
        else
          size = 12'(widest - 24 - $urandom_range(7));
      end else if ($urandom_range(3) == 0) begin
        size = 12'($urandom_range(200, 1));
      end else begin
        size = 12'($urandom_range(24, 1));
      end
      put_request(size, 1'b0, '0);
    end
    @(negedge clk_i);
    s_valid <= 1'b0;

    wait (pending_grants.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
